// ----- hw/rtl/fuzzy_set_inclusion_pri_assert.svh -----
// Assertion macros shared by the fuzzy-set inclusion block.
// Each macro checks on the rising edge of clk and is off while rst is high.
`ifndef FUZZY_SET_INCLUSION_PRI_ASSERT_SVH
`define FUZZY_SET_INCLUSION_PRI_ASSERT_SVH

// Same-cycle implication.
`define FSIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fsip_pkg.sv -----
// Shared constants, types and state codes of the fuzzy-set inclusion block.
// No dependencies; every other RTL file but the assertion macro header refers to it by scoped names.
package fsip_pkg;

  localparam int NUM_COND = 4;
  localparam int VAL_W    = 9;
  localparam int CODE_W   = 4;
  localparam int CODES_W  = NUM_COND * CODE_W;
  localparam int SUM_W    = 21;
  localparam int CNT_W    = 13;
  localparam int FRAC_W   = 16;
  localparam int RATIO_W  = FRAC_W + 1;
  localparam int MASK_W   = NUM_COND;
  localparam int NCOND_W  = 3;
  localparam int STEP_W   = 4;

  // Input item layout, lowest field first.
  localparam int CODES_LSB   = NUM_COND * VAL_W;
  localparam int OUTCOME_LSB = CODES_LSB + CODES_W;
  localparam int IN_W        = 64;

  // Result item layout, lowest field first.
  localparam int CUT_LSB = VAL_W;
  localparam int INC_LSB = CUT_LSB + CNT_W;
  localparam int PRI_LSB = INC_LSB + RATIO_W;
  localparam int OUT_W   = PRI_LSB + RATIO_W;
  localparam int USER_W  = 3;

  localparam logic [VAL_W-1:0]   ONE_Q8  = 9'd256;
  localparam logic [VAL_W-1:0]   HALF_Q8 = 9'd128;
  localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic {
    CFG_FUZZY_MASK,
    CFG_COND_IN_USE
  } cfg_index_t;

  typedef enum logic {
    DIV_INC,
    DIV_PRI
  } div_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_DSTART,
    S_DSTEP,
    S_DSAVE,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     accum;
    logic     div_start;
    logic     div_step;
    div_sel_t div_sel;
    logic     div_save;
    logic     load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- hw/rtl/fuzzy_set_inclusion_pri.sv -----
// Fuzzy-set inclusion and PRI accumulator, top level.
// Sequence: a row that is not last is captured, accumulated and loaded into the result register;
// the last row of a group also runs the shared divider's 16 steps twice, before the load.
// One item in flight; a waiting result lets one more row in, which then stalls until the
// result is taken. Reset (rst, synchronous, active high) clears the sums, sets fuzzy_mask 0,
// conditions_in_use 4.
module fuzzy_set_inclusion_pri (
  input  logic                          clk,
  input  logic                          rst,
  // Input items.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, lowest bit up: cond_value_0 [8:0], cond_value_1 [17:9],
  // cond_value_2 [26:18], cond_value_3 [35:27], row_codes [51:36],
  // outcome_value [60:52], zero fill [63:61].
  input  logic [fsip_pkg::IN_W-1:0]     s_tdata,
  input  logic                          s_tlast,   // last_row
  // Result items.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, lowest bit up: row_membership [8:0], cut_count [21:9],
  // inclusion [38:22], pri_score [55:39].
  output logic [fsip_pkg::OUT_W-1:0]    m_tdata,
  // m_tuser, lowest bit up: summary_valid [0], inclusion_undefined [1],
  // pri_undefined [2].
  output logic [fsip_pkg::USER_W-1:0]   m_tuser,
  // Configuration writes: index 0 is fuzzy_mask, index 1 is conditions_in_use.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [fsip_pkg::MASK_W-1:0]   cfg_data
);

  fsip_pkg::ctrl_cmd_t    cmd;
  fsip_pkg::ctrl_status_t status;

  // Configuration registers are plain flops, so a write is taken in every cycle
  // outside reset.
  assign cfg_ready = !rst;

  // The controller sequences capture, accumulation, the two divisions and the
  // hand-off to the result register.
  fsip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the membership logic, the group
  // sums, the divider and the output register.
  fsip_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

// ----- hw/rtl/fsip_ctrl.sv -----
// Controller state machine of the fuzzy-set inclusion block.
// Depends on fsip_pkg and the assertion macro header.
`include "fuzzy_set_inclusion_pri_assert.svh"

module fsip_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsip_pkg::ctrl_status_t status,
  output fsip_pkg::ctrl_cmd_t   cmd
);

  fsip_pkg::state_t   state, state_next;
  fsip_pkg::div_sel_t sel, sel_next;
  logic [fsip_pkg::STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsip_pkg::S_IDLE;
      sel   <= fsip_pkg::DIV_INC;
      cnt   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.div_sel = sel;
    case (state)
      fsip_pkg::S_IDLE: begin
        // No item is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = fsip_pkg::S_ACCUM;
        end
      end
      fsip_pkg::S_ACCUM: begin
        cmd.accum = 1'b1;
        if (status.last) begin
          sel_next   = fsip_pkg::DIV_INC;
          state_next = fsip_pkg::S_DSTART;
        end else begin
          state_next = fsip_pkg::S_LOAD;
        end
      end
      fsip_pkg::S_DSTART: begin
        cmd.div_start = 1'b1;
        cnt_next      = '0;
        state_next    = fsip_pkg::S_DSTEP;
      end
      fsip_pkg::S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == fsip_pkg::STEP_W'(fsip_pkg::FRAC_W - 1)) begin
          state_next = fsip_pkg::S_DSAVE;
        end
      end
      fsip_pkg::S_DSAVE: begin
        cmd.div_save = 1'b1;
        if (sel == fsip_pkg::DIV_INC) begin
          sel_next   = fsip_pkg::DIV_PRI;
          state_next = fsip_pkg::S_DSTART;
        end else begin
          state_next = fsip_pkg::S_LOAD;
        end
      end
      fsip_pkg::S_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = fsip_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fsip_pkg::S_IDLE;
      end
    endcase
  end

  // Short names for the checks below.
  logic [5:0] cmd_pulses;
  logic       last_step;

  assign cmd_pulses = {cmd.capture, cmd.accum, cmd.div_start,
                       cmd.div_step, cmd.div_save, cmd.load};
  assign last_step  = (state == fsip_pkg::S_DSTEP)
                      && (cnt == fsip_pkg::STEP_W'(fsip_pkg::FRAC_W - 1));

  `FSIP_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd_pulses), "more than one datapath command")
  `FSIP_ASSERT_NEXT(a_step_end, last_step, state == fsip_pkg::S_DSAVE, "divider overran")
  `FSIP_ASSERT_NEXT(a_plain_row, cmd.accum && !status.last, state == fsip_pkg::S_LOAD, "row to divider")
  `FSIP_ASSERT_NEXT(a_load_idle, cmd.load, in_ready, "block not ready after handing off a result")

endmodule

// ----- hw/rtl/fsip_div.sv -----
// Shared restoring divider: one quotient bit per step, Q1.16 result saturated at 1.0.
// Depends on fsip_pkg.
module fsip_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [fsip_pkg::SUM_W-1:0]    num,
  input  logic [fsip_pkg::SUM_W-1:0]    den,
  output logic [fsip_pkg::RATIO_W-1:0]  quo,
  output logic                          undef
);

  logic [fsip_pkg::SUM_W-1:0]  rem;
  logic [fsip_pkg::SUM_W-1:0]  den_r;
  logic [fsip_pkg::FRAC_W-1:0] q;
  logic                        sat;
  logic                        undef_r;
  logic [fsip_pkg::SUM_W:0]    trial;
  logic [fsip_pkg::SUM_W:0]    diff;

  assign trial = {rem, 1'b0};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num;
      den_r   <= den;
      q       <= '0;
      undef_r <= (den == '0);
      // A numerator at or above the denominator gives a ratio of 1.0 or more.
      sat     <= (num >= den);
    end else if (step) begin
      if (trial >= {1'b0, den_r}) begin
        rem <= diff[fsip_pkg::SUM_W-1:0];
        q   <= {q[fsip_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem <= trial[fsip_pkg::SUM_W-1:0];
        q   <= {q[fsip_pkg::FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign quo   = undef_r ? '0 : (sat ? fsip_pkg::ONE_Q16 : {1'b0, q});
  assign undef = undef_r;

endmodule

// ----- hw/rtl/fsip_dp.sv -----
// Datapath of the fuzzy-set inclusion block: configuration, row membership,
// accumulators, ratio divider and result register. Depends on fsip_pkg and fsip_div.
module fsip_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fsip_pkg::MASK_W-1:0]   cfg_data,
  input  logic [fsip_pkg::IN_W-1:0]     in_data,
  input  logic                          in_last,
  input  fsip_pkg::ctrl_cmd_t           cmd,
  output fsip_pkg::ctrl_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsip_pkg::OUT_W-1:0]    out_data,
  output logic [fsip_pkg::USER_W-1:0]   out_user
);

  localparam int VW = fsip_pkg::VAL_W;
  localparam int SW = fsip_pkg::SUM_W;

  function automatic logic [VW-1:0] clamp_one(input logic [VW-1:0] v);
    return (v > fsip_pkg::ONE_Q8) ? fsip_pkg::ONE_Q8 : v;
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [VW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + (SW + 1)'(b);
    return s[SW] ? '1 : s[SW-1:0];
  endfunction

  // Configuration registers.
  logic [fsip_pkg::MASK_W-1:0]  fuzzy_mask;
  logic [fsip_pkg::NCOND_W-1:0] cond_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      fuzzy_mask  <= '0;
      cond_in_use <= fsip_pkg::NCOND_W'(fsip_pkg::NUM_COND);
    end else if (cfg_we) begin
      case (fsip_pkg::cfg_index_t'(cfg_index))
        fsip_pkg::CFG_FUZZY_MASK:  fuzzy_mask  <= cfg_data;
        fsip_pkg::CFG_COND_IN_USE: cond_in_use <= cfg_data[fsip_pkg::NCOND_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic [VW-1:0]                cv [fsip_pkg::NUM_COND];
  logic [fsip_pkg::CODES_W-1:0] codes_r;
  logic [VW-1:0]                outcome_r;
  logic                         last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int j = 0; j < fsip_pkg::NUM_COND; j++) begin
        cv[j] <= in_data[j*VW +: VW];
      end
      codes_r   <= in_data[fsip_pkg::CODES_LSB +: fsip_pkg::CODES_W];
      outcome_r <= in_data[fsip_pkg::OUTCOME_LSB +: VW];
      last_r    <= in_last;
    end
  end

  // Row membership and its contributions.
  logic [fsip_pkg::NCOND_W-1:0] n_eff;
  logic [VW-1:0] m, o, c, p;

  always_comb begin
    logic [fsip_pkg::CODE_W-1:0] code;
    logic [VW-1:0]               t;
    if (cond_in_use == '0) begin
      n_eff = fsip_pkg::NCOND_W'(1);
    end else if (cond_in_use > fsip_pkg::NCOND_W'(fsip_pkg::NUM_COND)) begin
      n_eff = fsip_pkg::NCOND_W'(fsip_pkg::NUM_COND);
    end else begin
      n_eff = cond_in_use;
    end
    m = fsip_pkg::ONE_Q8;
    for (int j = 0; j < fsip_pkg::NUM_COND; j++) begin
      code = codes_r[j*fsip_pkg::CODE_W +: fsip_pkg::CODE_W];
      if (fuzzy_mask[j]) begin
        t = clamp_one(cv[j]);
        // Code zero asks for the negated condition.
        if (code == '0) begin
          t = fsip_pkg::ONE_Q8 - t;
        end
      end else begin
        t = (cv[j] == VW'(code)) ? fsip_pkg::ONE_Q8 : '0;
      end
      if ((fsip_pkg::NCOND_W'(j) < n_eff) && (t < m)) begin
        m = t;
      end
    end
    o = clamp_one(outcome_r);
    c = (m < o) ? m : o;
    p = (c < (fsip_pkg::ONE_Q8 - o)) ? c : (fsip_pkg::ONE_Q8 - o);
  end

  // Accumulators.
  logic [SW-1:0]              mem_sum, cons_sum, pri_sum;
  logic [fsip_pkg::CNT_W-1:0] cut_cnt;
  logic [SW-1:0]              mem_next, cons_next, pri_next;
  logic [fsip_pkg::CNT_W-1:0] cut_next;

  assign mem_next  = sat_add(mem_sum, m);
  assign cons_next = sat_add(cons_sum, c);
  assign pri_next  = sat_add(pri_sum, p);
  assign cut_next  = ((m > fsip_pkg::HALF_Q8) && (cut_cnt != '1)) ? cut_cnt + 1'b1 : cut_cnt;

  // Group totals held for the divider.
  logic [SW-1:0]              inc_num, inc_den, pri_num, pri_den;
  logic [VW-1:0]              m_r;
  logic [fsip_pkg::CNT_W-1:0] cut_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_sum  <= '0;
      cons_sum <= '0;
      pri_sum  <= '0;
      cut_cnt  <= '0;
    end else if (cmd.accum) begin
      if (last_r) begin
        mem_sum  <= '0;
        cons_sum <= '0;
        pri_sum  <= '0;
        cut_cnt  <= '0;
      end else begin
        mem_sum  <= mem_next;
        cons_sum <= cons_next;
        pri_sum  <= pri_next;
        cut_cnt  <= cut_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      m_r     <= m;
      cut_r   <= cut_next;
      inc_num <= cons_next;
      inc_den <= mem_next;
      pri_num <= (cons_next > pri_next) ? cons_next - pri_next : '0;
      pri_den <= (mem_next > pri_next) ? mem_next - pri_next : '0;
    end
  end

  // Ratio divider, shared by inclusion and PRI.
  logic [fsip_pkg::RATIO_W-1:0] quo;
  logic                         undef;
  logic [fsip_pkg::RATIO_W-1:0] inc_q, pri_q;
  logic                         inc_undef, pri_undef;

  fsip_div u_div (
    .clk   (clk),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .num   ((cmd.div_sel == fsip_pkg::DIV_INC) ? inc_num : pri_num),
    .den   ((cmd.div_sel == fsip_pkg::DIV_INC) ? inc_den : pri_den),
    .quo   (quo),
    .undef (undef)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_save) begin
      if (cmd.div_sel == fsip_pkg::DIV_INC) begin
        inc_q     <= quo;
        inc_undef <= undef;
      end else begin
        pri_q     <= quo;
        pri_undef <= undef;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (last_r) begin
        out_data <= {pri_q, inc_q, cut_r, m_r};
        out_user <= {pri_undef, inc_undef, 1'b1};
      end else begin
        out_data <= {{(fsip_pkg::OUT_W - VW){1'b0}}, m_r};
        out_user <= '0;
      end
    end
  end

  assign status.last     = last_r;
  assign status.out_free = !out_valid || out_ready;

endmodule
